// ===== design/tpae_pkg.sv =====
// Shared constants, codes and the erfc table helper for the alpha evaluator.
package tpae_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_D_ZERO = 2'd1;
  localparam status_t STATUS_SAT    = 2'd2;

  localparam logic [2:0] REG_BLEND_WIDTH       = 3'd0;
  localparam logic [2:0] REG_CROSSOVER_POINT   = 3'd1;
  localparam logic [2:0] REG_EPITHERMAL_OFFSET = 3'd2;
  localparam logic [2:0] REG_EPITHERMAL_SLOPE  = 3'd3;
  localparam logic [2:0] REG_THERMAL_OFFSET    = 3'd4;
  localparam logic [2:0] REG_THERMAL_SLOPE     = 3'd5;

  localparam logic [31:0] ALPHA_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALPHA_MIN = 32'h8000_0000;

  localparam logic [63:0] ERFC_COEF [6] = '{
    64'd18930895, 64'd11349991, 64'd2488538, 64'd40806, 64'd74240, 64'd11560
  };

  // restoring shift-subtract quotient, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // erfc(x) for x >= 0 in Q28, rational approximation raised to the -16th power
  function automatic logic [63:0] erfc_pos_q28(input logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] inv;
    acc = ERFC_COEF[5];
    for (int i = 4; i >= 0; i--) begin
      acc = ((acc * x) >> 28) + ERFC_COEF[i];
    end
    acc = ((acc * x) >> 28) + (64'd1 << 28);
    inv = udiv64(64'd1 << 56, acc);
    for (int i = 0; i < 4; i++) begin
      inv = (inv * inv) >> 28;
    end
    return inv;
  endfunction

endpackage

// ===== design/tpae_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic stages.
module tpae_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        line[i] <= '0;
      end
    end else if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

// ===== design/tpae_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tpae_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // numerator bits leave at the top while quotient bits enter at the bottom
  logic [NUM_W-1:0] nq_s  [1:NUM_W];
  logic [DEN_W-1:0] rem_s [1:NUM_W-1];
  logic [DEN_W-1:0] den_s [1:NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign nq_in  = nq_s[k];
      assign rem_in = rem_s[k];
      assign den_in = den_s[k];
    end

    always_comb begin
      trial = {rem_in, nq_in[NUM_W-1]};
      ge    = trial >= {1'b0, den_in};
      diff  = ge ? (trial - {1'b0, den_in}) : trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_s[k+1] <= {nq_in[NUM_W-2:0], ge};
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= diff[DEN_W-1:0];
          den_s[k+1] <= den_in;
        end
      end
    end
  end

  assign quo = nq_s[NUM_W];

endmodule

// ===== design/tpae_blend.sv =====
// Blend weight n = 0.5*erfc(width*diff) from an interpolated table, five stages.
module tpae_blend #(
  parameter int ENTRIES   = 1024,
  parameter int FRAC_BITS = 16,
  parameter int DIFF_W    = 49
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [31:0]       blend_width,
  input  logic signed [DIFF_W-1:0] diff,
  output logic [FRAC_BITS:0]       n
);

  localparam int N_W   = FRAC_BITS + 1;
  localparam int FR_W  = FRAC_BITS + 3;
  localparam int U_W   = FRAC_BITS + 4;
  localparam int IDX_W = $clog2(ENTRIES + 1);
  localparam int POS_W = U_W + IDX_W;
  localparam int I_W   = POS_W - FR_W;
  localparam int BH_W  = DIFF_W - FRAC_BITS;

  typedef logic [N_W-1:0] rom_t [ENTRIES+1];

  function automatic rom_t build_rom();
    rom_t               rom;
    logic signed [63:0] x;
    logic [63:0]        mag;
    logic [63:0]        half;
    logic [63:0]        n28;
    for (int k = 0; k <= ENTRIES; k++) begin
      x    = -64'sd1073741824
             + $signed(tpae_pkg::udiv64(64'd2147483648 * 64'(k), 64'(ENTRIES)));
      mag  = (x < 0) ? 64'(-x) : 64'(x);
      half = tpae_pkg::erfc_pos_q28(mag) >> 1;
      n28  = (x >= 0) ? half : ((64'd1 << 28) - half);
      rom[k] = N_W'((n28 + (64'd1 << (27 - FRAC_BITS))) >> (28 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  localparam logic [63:0]   CAP64 = 64'd4 << FRAC_BITS;
  localparam logic [FR_W-1:0] CAP = FR_W'(CAP64);

  // stage 1: magnitudes and the two partial products
  logic [31:0]         a_mag;
  logic [DIFF_W-1:0]   b_mag;
  logic [BH_W-1:0]     bh;
  logic [63:0]         ph1;
  logic [31+FRAC_BITS:0] pl1;
  logic                big1, azero1, neg1;

  always_comb begin
    a_mag = blend_width[31] ? 32'(-blend_width) : 32'(blend_width);
    b_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    bh    = b_mag[DIFF_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1    <= 64'(a_mag) * 64'(bh[31:0]);
      pl1    <= (32 + FRAC_BITS)'(a_mag) * (32 + FRAC_BITS)'(b_mag[FRAC_BITS-1:0]);
      big1   <= (bh >> 32) != '0;
      azero1 <= a_mag == '0;
      neg1   <= blend_width[31] != diff[DIFF_W-1];
    end
  end

  // stage 2: clamp the argument and find the table position
  logic [63:0]      m;
  logic [FR_W-1:0]  mc;
  logic [U_W-1:0]   u;
  logic [POS_W-1:0] pos;
  logic [I_W-1:0]   ipos;
  logic [IDX_W-1:0] i0_next, i1_next;
  logic [FR_W-1:0]  fr_next;
  logic [IDX_W-1:0] i0, i1;
  logic [FR_W-1:0]  fr2, fr3;

  always_comb begin
    m = ph1;
    if (azero1) begin
      mc = '0;
    end else if (big1) begin
      mc = CAP;
    end else begin
      if (m < CAP64) begin
        m = m + 64'(pl1 >> FRAC_BITS);
      end
      if (m > CAP64) begin
        m = CAP64;
      end
      mc = m[FR_W-1:0];
    end
    u    = neg1 ? (U_W'(CAP) - U_W'(mc)) : (U_W'(CAP) + U_W'(mc));
    pos  = POS_W'(u) * POS_W'(ENTRIES);
    ipos = pos[POS_W-1:FR_W];
    if (ipos >= I_W'(ENTRIES)) begin
      i0_next = IDX_W'(ENTRIES);
      i1_next = IDX_W'(ENTRIES);
      fr_next = '0;
    end else begin
      i0_next = IDX_W'(ipos);
      i1_next = IDX_W'(ipos) + IDX_W'(1);
      fr_next = pos[FR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i0  <= i0_next;
      i1  <= i1_next;
      fr2 <= fr_next;
    end
  end

  // stage 3: table reads
  logic [N_W-1:0] v0, v1;

  always_ff @(posedge clk) begin
    if (en) begin
      v0  <= ROM[i0];
      v1  <= ROM[i1];
      fr3 <= fr2;
    end
  end

  // stage 4: slope times fraction
  logic [N_W+FR_W-1:0] prod4;
  logic [N_W-1:0]      v0_4;
  logic                down4;

  always_ff @(posedge clk) begin
    if (en) begin
      prod4 <= (N_W + FR_W)'((v0 >= v1) ? (v0 - v1) : (v1 - v0)) * (N_W + FR_W)'(fr3);
      v0_4  <= v0;
      down4 <= v0 >= v1;
    end
  end

  // stage 5: interpolate
  always_ff @(posedge clk) begin
    if (en) begin
      n <= down4 ? (v0_4 - prod4[N_W+FR_W-1:FR_W]) : (v0_4 + prod4[N_W+FR_W-1:FR_W]);
    end
  end

endmodule

// ===== design/tof_profile_alpha_eval.sv =====
// Top level of the peak-shape alpha evaluator: registers, pipeline and output skid.
//
// Use: d-spacing items (unsigned Q8.16 by default) enter on the s_ stream, one per
// cycle while s_tready is high; each gives one alpha item (signed Q16.16) with a status
// code on the m_ stream, in order, with the last mark copied. The user must see that
// settings are written over the APB port only while the block is idle; the block does
// not enforce it. They read back at the same addresses. Items pass the input register,
// a reciprocal divider of FRAC_BITS+32 stages, eight arithmetic and table stages, a
// final divider of 3*FRAC_BITS+2 stages, the rounding register and the output
// register, the first of them loaded at the accepting edge. Both dividers resolve one
// quotient bit per stage, so one item is accepted every cycle while the skid is empty.
// Reset clears all valid bits, holds s_tready low and loads the default settings
// (width and crossover 1.0, branch terms zero); the erfc table is a constant.
// When the receiver stalls, the output register holds its item and a skid
// register takes one more; the pipeline and s_tready then hold until the skid
// drains, so nothing is dropped or repeated.
module tof_profile_alpha_eval #(
  parameter int ERFC_TABLE_ENTRIES = 1024,
  parameter int FRAC_BITS          = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] d_spacing
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] alpha_value, [33:32] status_code, rest zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F      = FRAC_BITS;
  localparam int DNUM_W = F + 32;
  localparam int DIFF_W = F + 33;
  localparam int T_W    = F + 34;
  localparam int P_W    = 57;
  localparam int E_W    = 58 - F;
  localparam int PE_W   = E_W + F + 2;
  localparam int PT_W   = T_W + F + 2;
  localparam int DM_W   = 63;
  localparam int QN_W   = 3 * F + 2;
  localparam int QX_W   = (3 * F + 2 > 34) ? 3 * F + 2 : 34;
  localparam int N_W    = F + 1;
  localparam int ALIGN  = 4;
  localparam logic signed [65:0] T_LIM = 66'sd1 <<< (62 - F);

  // configuration
  logic signed [31:0] w_reg, tc_reg, a0_reg, a1_reg, a0t_reg, a1t_reg;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg   <= 32'sd1 <<< F;
      tc_reg  <= 32'sd1 <<< F;
      a0_reg  <= '0;
      a1_reg  <= '0;
      a0t_reg <= '0;
      a1t_reg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_idx)
        tpae_pkg::REG_BLEND_WIDTH:       w_reg   <= pwdata;
        tpae_pkg::REG_CROSSOVER_POINT:   tc_reg  <= pwdata;
        tpae_pkg::REG_EPITHERMAL_OFFSET: a0_reg  <= pwdata;
        tpae_pkg::REG_EPITHERMAL_SLOPE:  a1_reg  <= pwdata;
        tpae_pkg::REG_THERMAL_OFFSET:    a0t_reg <= pwdata;
        tpae_pkg::REG_THERMAL_SLOPE:     a1t_reg <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tpae_pkg::REG_BLEND_WIDTH:       prdata = w_reg;
      tpae_pkg::REG_CROSSOVER_POINT:   prdata = tc_reg;
      tpae_pkg::REG_EPITHERMAL_OFFSET: prdata = a0_reg;
      tpae_pkg::REG_EPITHERMAL_SLOPE:  prdata = a1_reg;
      tpae_pkg::REG_THERMAL_OFFSET:    prdata = a0t_reg;
      tpae_pkg::REG_THERMAL_SLOPE:     prdata = a1t_reg;
      default:                         prdata = '0;
    endcase
  end

  // pipeline advances whenever the skid register is free
  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign s_tready = en && !rst;

  // input stage
  logic        v0, last0;
  logic [23:0] d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0    <= s_tdata;
      last0 <= s_tlast;
    end
  end

  // reciprocal and thermal quotient
  logic [31:0]       a1t_mag;
  logic [DNUM_W-1:0] r_num, t_num, rq, tq;

  always_comb begin
    a1t_mag = a1t_reg[31] ? 32'(-a1t_reg) : 32'(a1t_reg);
    r_num   = (DNUM_W'(1) << (2 * F)) + DNUM_W'(d0[23:1]);
    t_num   = (DNUM_W'(a1t_mag) << F) + DNUM_W'(d0[23:1]);
  end

  tpae_div #(.NUM_W(DNUM_W), .DEN_W(24)) u_div_r (
    .clk(clk), .en(en), .num(r_num), .den(d0), .quo(rq)
  );

  tpae_div #(.NUM_W(DNUM_W), .DEN_W(24)) u_div_t (
    .clk(clk), .en(en), .num(t_num), .den(d0), .quo(tq)
  );

  logic [25:0] side1_in, side1_out;
  assign side1_in = {v0, last0, d0};

  tpae_delay #(.W(26), .DEPTH(DNUM_W)) u_side1 (
    .clk(clk), .rst(rst), .en(en), .din(side1_in), .dout(side1_out)
  );

  logic        v_d1, last_d1;
  logic [23:0] d_d1;
  assign {v_d1, last_d1, d_d1} = side1_out;

  // P1: crossover difference, thermal term, epithermal product
  logic signed [DIFF_W-1:0] diff1;
  logic signed [T_W-1:0]    t1;
  logic signed [P_W-1:0]    p1;
  logic                     v1, last1, dz1;
  logic signed [T_W-1:0]    tq_s;

  assign tq_s = $signed({2'b00, tq});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1 <= DIFF_W'(tc_reg) - $signed({1'b0, rq});
      t1    <= a1t_reg[31] ? (T_W'(a0t_reg) + tq_s) : (T_W'(a0t_reg) - tq_s);
      p1    <= P_W'(a1_reg) * P_W'($signed({1'b0, d_d1}));
      last1 <= last_d1;
      dz1   <= d_d1 == '0;
    end
  end

  // blend weight, five stages from diff1
  logic [N_W-1:0] n5;

  tpae_blend #(.ENTRIES(ERFC_TABLE_ENTRIES), .FRAC_BITS(F), .DIFF_W(DIFF_W)) u_blend (
    .clk(clk), .en(en), .blend_width(w_reg), .diff(diff1), .n(n5)
  );

  // P2: epithermal term and thermal range check
  logic [P_W-1:0]       pm;
  logic [P_W-1:0]       psum;
  logic [P_W-F-1:0]     mr;
  logic signed [65:0]   tx;
  logic signed [E_W-1:0] e2;
  logic signed [T_W-1:0] t2;
  logic                 v2, last2, dz2, tbig2;

  always_comb begin
    pm   = p1[P_W-1] ? P_W'(-p1) : P_W'(p1);
    psum = pm + (P_W'(1) << (F - 1));
    mr   = psum[P_W-1:F];
    tx   = 66'(t1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2    <= p1[P_W-1] ? (E_W'(a0_reg) - $signed({1'b0, mr}))
                         : (E_W'(a0_reg) + $signed({1'b0, mr}));
      t2    <= t1;
      tbig2 <= (tx >= T_LIM) || (tx <= -T_LIM);
      last2 <= last1;
      dz2   <= dz1;
    end
  end

  localparam int S2_W = 4 + E_W + T_W;
  logic [S2_W-1:0] side2_in, side2_out;
  assign side2_in = {v2, last2, dz2, tbig2, e2, t2};

  tpae_delay #(.W(S2_W), .DEPTH(ALIGN)) u_side2 (
    .clk(clk), .rst(rst), .en(en), .din(side2_in), .dout(side2_out)
  );

  logic                  v_a, last_a, dz_a, tbig_a;
  logic signed [E_W-1:0] e_a;
  logic signed [T_W-1:0] t_a;
  assign {v_a, last_a, dz_a, tbig_a, e_a, t_a} = side2_out;

  // D1: weighted branch products
  logic signed [PE_W-1:0] pe;
  logic signed [PT_W-1:0] pt;
  logic [N_W-1:0]         nt;
  logic                   v3, last3, dz3, tbig3;

  assign nt = (N_W'(1) << F) - n5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe    <= PE_W'($signed({1'b0, n5})) * PE_W'(e_a);
      pt    <= PT_W'($signed({1'b0, nt})) * PT_W'(t_a);
      last3 <= last_a;
      dz3   <= dz_a;
      tbig3 <= tbig_a;
    end
  end

  // D2: denominator
  logic signed [63:0] den;
  logic [DM_W-1:0]    dm4;
  logic               v4, last4, dz4, tbig4, dzero4, dneg4;

  assign den = 64'(pe) + 64'(pt);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm4    <= den[63] ? DM_W'(-den) : DM_W'(den);
      dzero4 <= den == '0;
      dneg4  <= den[63];
      last4  <= last3;
      dz4    <= dz3;
      tbig4  <= tbig3;
    end
  end

  // final reciprocal 2^(3F+1) / |den|
  logic [QN_W-1:0] qf;

  tpae_div #(.NUM_W(QN_W), .DEN_W(DM_W)) u_div_a (
    .clk(clk), .en(en), .num(QN_W'(1) << (3 * F + 1)), .den(dm4), .quo(qf)
  );

  logic [5:0] side3_in, side3_out;
  assign side3_in = {v4, last4, dz4, tbig4, dzero4, dneg4};

  tpae_delay #(.W(6), .DEPTH(QN_W)) u_side3 (
    .clk(clk), .rst(rst), .en(en), .din(side3_in), .dout(side3_out)
  );

  logic v_b, last_b, dz_b, tbig_b, dzero_b, dneg_b;
  assign {v_b, last_b, dz_b, tbig_b, dzero_b, dneg_b} = side3_out;

  // Z: round, saturate, pick special cases
  logic [QX_W-1:0]   qx;
  logic              ovf;
  logic [33:0]       qsum;
  logic [32:0]       mag, negm;
  logic [31:0]       alpha_next;
  tpae_pkg::status_t status_next;

  always_comb begin
    qx   = QX_W'(qf);
    ovf  = qx[QX_W-1:33] != '0;
    qsum = qx[33:0] + 34'd1;
    mag  = qsum[33:1];
    negm = 33'd0 - mag;
    priority if (dz_b) begin
      alpha_next  = tpae_pkg::ALPHA_MAX;
      status_next = tpae_pkg::STATUS_D_ZERO;
    end else if (tbig_b) begin
      alpha_next  = '0;
      status_next = tpae_pkg::STATUS_SAT;
    end else if (dzero_b) begin
      alpha_next  = tpae_pkg::ALPHA_MAX;
      status_next = tpae_pkg::STATUS_SAT;
    end else if (!dneg_b) begin
      if (ovf || (mag > 33'h0_7FFF_FFFF)) begin
        alpha_next  = tpae_pkg::ALPHA_MAX;
        status_next = tpae_pkg::STATUS_SAT;
      end else begin
        alpha_next  = mag[31:0];
        status_next = tpae_pkg::STATUS_OK;
      end
    end else begin
      if (ovf || (mag > 33'h0_8000_0000)) begin
        alpha_next  = tpae_pkg::ALPHA_MIN;
        status_next = tpae_pkg::STATUS_SAT;
      end else begin
        alpha_next  = negm[31:0];
        status_next = tpae_pkg::STATUS_OK;
      end
    end
  end

  logic              z_v, z_last;
  logic [31:0]       z_alpha;
  tpae_pkg::status_t z_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_v <= 1'b0;
    end else if (en) begin
      z_v <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_alpha  <= alpha_next;
      z_status <= status_next;
      z_last   <= last_b;
    end
  end

  // output register and skid
  logic [31:0]       out_alpha, skid_alpha;
  tpae_pkg::status_t out_status, skid_status;
  logic              out_last, skid_last;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (en) begin
      if (out_free) begin
        m_tvalid <= z_v;
      end else if (z_v) begin
        skid_v <= 1'b1;
      end
    end else if (out_free) begin
      m_tvalid <= 1'b1;
      skid_v   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_free) begin
        out_alpha  <= z_alpha;
        out_status <= z_status;
        out_last   <= z_last;
      end else begin
        skid_alpha  <= z_alpha;
        skid_status <= z_status;
        skid_last   <= z_last;
      end
    end else if (out_free) begin
      out_alpha  <= skid_alpha;
      out_status <= skid_status;
      out_last   <= skid_last;
    end
  end

  assign m_tdata = {6'd0, out_status, out_alpha};
  assign m_tlast = out_last;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the alpha evaluator: directed, register and random item tests.
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC = 16;
  localparam int ROM_N = 1024;
  localparam int LATENCY = 4 * FRAC + 45;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint unsigned Q28 = 64'd1 << 28;

  typedef struct packed {
    logic [31:0]       alpha;
    tpae_pkg::status_t status;
    logic              last;
  } alpha_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;     // [23:0] d_spacing
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [31:0] alpha_value, [33:32] status_code, rest zero
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tof_profile_alpha_eval uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] n_table [0:ROM_N];
  logic [31:0] settings [6];
  alpha_res_t  pending_alpha [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  longint cycles = 0;

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned half_erfc_pos(input longint unsigned x);
    longint unsigned coef [6];
    longint unsigned acc;
    longint unsigned inv;
    coef = '{64'd18930895, 64'd11349991, 64'd2488538, 64'd40806, 64'd74240, 64'd11560};
    acc = coef[5];
    for (int i = 4; i >= 0; i--) acc = ((acc * x) >> 28) + coef[i];
    acc = ((acc * x) >> 28) + Q28;
    inv = (64'd1 << 56) / acc;
    for (int i = 0; i < 4; i++) inv = (inv * inv) >> 28;
    return inv;
  endfunction

  task automatic build_n_table();
    longint x;
    longint unsigned h;
    longint unsigned n28;
    for (int k = 0; k <= ROM_N; k++) begin
      x = -longint'(4 * Q28) + longint'(8 * Q28) * k / ROM_N;
      h = half_erfc_pos(magnitude(x)) >> 1;
      n28 = x >= 0 ? h : Q28 - h;
      n_table[k] = 32'((n28 + (64'd1 << (27 - FRAC))) >> (28 - FRAC));
    end
  endtask

  function automatic longint unsigned blend(input longint w, input longint diff);
    longint unsigned cap, a, b, bh, bl, m, u, pos, idx, fr, v0, v1;
    logic flip;
    cap = 64'd4 << FRAC;
    a = magnitude(w);
    b = magnitude(diff);
    bh = b >> FRAC;
    bl = b & ((64'd1 << FRAC) - 1);
    flip = (w < 0) != (diff < 0);
    if (a == 0) m = 0;
    else if (bh >= (64'd1 << 32)) m = cap;
    else begin
      m = a * bh;
      if (m < cap) m += (a * bl) >> FRAC;
      if (m > cap) m = cap;
    end
    u = flip ? cap - m : cap + m;
    pos = u * ROM_N;
    idx = pos >> (FRAC + 3);
    fr = pos & ((64'd1 << (FRAC + 3)) - 1);
    if (idx >= ROM_N) return n_table[ROM_N];
    v0 = n_table[idx];
    v1 = n_table[idx + 1];
    if (v0 >= v1) return v0 - (((v0 - v1) * fr) >> (FRAC + 3));
    return v0 + (((v1 - v0) * fr) >> (FRAC + 3));
  endfunction

  function automatic alpha_res_t predict_alpha(input logic [23:0] d_in, input logic last);
    alpha_res_t res;
    longint unsigned d, one, r, n, m, dm, rem, q, mag;
    longint w, tc, a0, a1, a0t, a1t, e, t, den, lim, p;
    logic ovf;
    int top;
    res.last = last;
    d = d_in;
    one = 64'd1 << FRAC;
    top = 3 * FRAC + 1;
    ovf = 1'b0;
    if (d == 0) begin
      res.alpha = tpae_pkg::ALPHA_MAX;
      res.status = tpae_pkg::STATUS_D_ZERO;
      return res;
    end
    w = longint'(signed'(settings[tpae_pkg::REG_BLEND_WIDTH]));
    tc = longint'(signed'(settings[tpae_pkg::REG_CROSSOVER_POINT]));
    a0 = longint'(signed'(settings[tpae_pkg::REG_EPITHERMAL_OFFSET]));
    a1 = longint'(signed'(settings[tpae_pkg::REG_EPITHERMAL_SLOPE]));
    a0t = longint'(signed'(settings[tpae_pkg::REG_THERMAL_OFFSET]));
    a1t = longint'(signed'(settings[tpae_pkg::REG_THERMAL_SLOPE]));
    r = ((64'd1 << (2 * FRAC)) + d / 2) / d;
    n = blend(w, tc - longint'(r));
    p = a1 * longint'(d);
    m = (magnitude(p) + (one >> 1)) >> FRAC;
    e = a0 + (p < 0 ? -longint'(m) : longint'(m));
    m = ((magnitude(a1t) << FRAC) + d / 2) / d;
    t = a0t - (a1t < 0 ? -longint'(m) : longint'(m));
    lim = longint'(64'd1 << (62 - FRAC));
    if (e >= lim || e <= -lim || t >= lim || t <= -lim) begin
      res.alpha = '0;
      res.status = tpae_pkg::STATUS_SAT;
      return res;
    end
    den = longint'(n) * e + longint'(one - n) * t;
    if (den == 0) begin
      res.alpha = tpae_pkg::ALPHA_MAX;
      res.status = tpae_pkg::STATUS_SAT;
      return res;
    end
    dm = magnitude(den);
    rem = 0;
    q = 0;
    for (int b = top; b >= 0; b--) begin
      rem = (rem << 1) | longint'(b == top);
      if (rem >= dm) begin
        rem -= dm;
        q = (q << 1) | 64'd1;
      end else begin
        q = q << 1;
      end
      if (q >= (64'd1 << 33)) begin
        ovf = 1'b1;
        break;
      end
    end
    mag = (q + 1) >> 1;
    res.status = tpae_pkg::STATUS_OK;
    if (den > 0) begin
      if (ovf || mag > 64'h7FFF_FFFF) begin
        res.alpha = tpae_pkg::ALPHA_MAX;
        res.status = tpae_pkg::STATUS_SAT;
      end else begin
        res.alpha = 32'(mag);
      end
    end else begin
      if (ovf || mag > 64'h8000_0000) begin
        res.alpha = tpae_pkg::ALPHA_MIN;
        res.status = tpae_pkg::STATUS_SAT;
      end else begin
        res.alpha = 32'((64'd1 << 32) - mag);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // receiver side: stall at random, then check each accepted item
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    alpha_res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_alpha.size() == 0) begin
        report_mismatch("unexpected item", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_alpha.pop_front();
        if (m_tdata[31:0] !== want.alpha)
          report_mismatch("alpha_value", m_tdata[31:0], want.alpha);
        if (m_tdata[33:32] !== want.status)
          report_mismatch("status_code", 32'(m_tdata[33:32]), 32'(want.status));
        if (m_tlast !== want.last)
          report_mismatch("out_last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // hold valid low for random gaps, then present one item until taken
  task automatic send_item(input logic [23:0] d, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    pending_alpha.push_back(predict_alpha(d, last));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_alpha.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input int idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < 6) settings[idx] = value;
    reg_writes++;
  endtask

  task automatic load_settings(input logic [31:0] w, tc, a0, a1, a0t, a1t);
    wait_drained();
    write_setting(tpae_pkg::REG_BLEND_WIDTH, w);
    write_setting(tpae_pkg::REG_CROSSOVER_POINT, tc);
    write_setting(tpae_pkg::REG_EPITHERMAL_OFFSET, a0);
    write_setting(tpae_pkg::REG_EPITHERMAL_SLOPE, a1);
    write_setting(tpae_pkg::REG_THERMAL_OFFSET, a0t);
    write_setting(tpae_pkg::REG_THERMAL_SLOPE, a1t);
  endtask

  function automatic logic [31:0] signed_q(input int whole_max);
    logic [31:0] v;
    v = 32'($urandom_range(whole_max << FRAC));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [23:0] random_d();
    unique case ($urandom_range(4))
      0: return 24'($urandom_range(1, 255));
      1: return 24'($urandom_range(24'h0_4000, 24'h4_0000));
      2: return 24'($urandom_range(1, 24'h1F_FFFF));
      3: return 24'($urandom);
      default: return $urandom_range(19) == 0 ? 24'd0 : 24'($urandom_range(1, 24'h0F_FFFF));
    endcase
  endfunction

  task automatic test_directed();
    logic [23:0] d_list [12];
    d_list = '{24'd0, 24'd1, 24'hFF_FFFF, 24'h01_0000, 24'h00_8000, 24'h02_0000,
               24'h80_0000, 24'd2, 24'h7F_FFFF, 24'h00_0100, 24'h10_0000, 24'h00_0001};
    // reset settings: both branches zero, so every nonzero d gives a zero denominator
    foreach (d_list[i]) send_item(d_list[i], i[0]);
    load_settings(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                  32'h0003_0000, 32'h0000_8000);
    foreach (d_list[i]) send_item(d_list[i], ~i[0]);
  endtask

  task automatic test_registers();
    // extremes of every setting, zero width, and writes to unused indexes
    load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) send_item(i < 2 ? 24'd1 : random_d(), i[0]);
    load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 8; i++) send_item(i < 2 ? 24'hFF_FFFF : random_d(), i[1]);
    load_settings(32'd0, 32'h0001_0000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0);
    write_setting(6, 32'hFFFF_FFFF);
    write_setting(7, 32'h1234_5678);
    for (int i = 0; i < 8; i++) send_item(random_d(), i[0]);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int sets,
                                   input int per_set);
    idle_pct = idle;
    stall_pct = stall;
    for (int s = 0; s < sets; s++) begin
      if ($urandom_range(3) == 0)
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_settings(signed_q(12), signed_q(4), signed_q(8), signed_q(8),
                      signed_q(8), signed_q(8));
      for (int i = 0; i < per_set; i++) begin
        // hold off once mid-set until the pipeline is empty
        if (s == 1 && i == per_set / 2) wait_drained();
        send_item(random_d(), $urandom_range(1));
      end
    end
  endtask

  initial begin
    build_n_table();
    settings = '{32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random_phase(0, 0, 5, 70);
    test_random_phase(69, 0, 5, 70);
    test_random_phase(0, 69, 5, 70);
    test_random_phase(18, 18, 5, 70);
    test_random_phase(0, 0, 1, 10);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register writes,",
             items_sent, results_seen, reg_writes);
    $display("with sender gaps and receiver stalls in separate and combined phases");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tpae_pkg.sv
design/tpae_delay.sv
design/tpae_div.sv
design/tpae_blend.sv
design/tof_profile_alpha_eval.sv
tb/sv/tb_top.sv
